// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/cma_pkg.sv =====
package cma_pkg;

	// Width of the window register and of the repeat count.
	localparam int WINDOW_BITS = 10;

	// Defaults for the top-level parameters.
	localparam int RING_DEPTH_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	// Window width after reset.
	localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 10'd101;

endpackage

// ===== sv/centered_moving_average_unit.sv =====
// An accepted input beat passes the stage-1, division-input, division and output registers.
// Throughput: one input beat per cycle; the ring memory port and the running-sum add both
// complete each cycle and the division is a SAMPLE_BITS-stage compare-subtract pipeline.
// Back-pressure on the output stalls the whole pipeline, input included.
// Reset (arst_n low, asynchronous): window width 101, running sum, fill count and ring
// pointer zero, pipeline empty; the ring memory itself is not cleared and needs no pass.
module centered_moving_average_unit #(
	parameter int RING_DEPTH  = cma_pkg::RING_DEPTH_DEF,
	parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,

	// Window width register.
	input  logic                           cfg_wr_en,
	input  logic [cma_pkg::WINDOW_BITS-1:0] cfg_wr_data,

	// Input stream. tdata, from bit 0: sample. tlast: last sample of the stream.
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
	input  logic                                 s_axis_tlast,

	// Result stream. tdata, from bit 0: average, repeat_count. tlast: stream done.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [((SAMPLE_BITS+cma_pkg::WINDOW_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic                                 m_axis_tlast
);
	import cma_pkg::*;

	`include "assert_macros.svh"

	localparam int OUT_W = ((SAMPLE_BITS + WINDOW_BITS + 7) / 8) * 8;
	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	// Wide enough for pointer plus depth before the wrap correction.
	localparam int IDX_W = PTR_W + 2;
	// The running sum of up to 1023 samples fits exactly in this width.
	localparam int SUM_W = SAMPLE_BITS + WINDOW_BITS;
	localparam int SB    = SAMPLE_BITS;

	// ------------------------------------------------------------------
	// Configuration and stream state.
	// ------------------------------------------------------------------
	logic [WINDOW_BITS-1:0] window_size_q;
	logic [WINDOW_BITS-1:0] seen_q;
	logic [PTR_W-1:0]       ptr_q;
	logic [SUM_W-1:0]       sum_q;

	// The whole pipeline moves together; it only holds while a finished result
	// waits in the output register and the sink is not taking it.
	logic advance;
	logic in_acc;
	logic out_vld_q;

	assign advance       = !out_vld_q || m_axis_tready;
	assign s_axis_tready = advance;
	assign in_acc        = s_axis_tvalid && advance;

	logic [SB-1:0] in_sample;
	assign in_sample = s_axis_tdata[SB-1:0];

	// A window is usable when it is odd and the ring can hold it. Anything else
	// still consumes beats but never produces a result.
	logic usable;
	assign usable = window_size_q[0] && (32'(window_size_q) <= 32'(RING_DEPTH));

	logic [WINDOW_BITS-1:0] half_w;
	assign half_w = window_size_q >> 1;

	// While the window is still filling, samples only add to the sum. The beat
	// that completes it emits the first average, which also stands for the
	// leading half-window. From then on every beat slides the window by one.
	logic                   filling;
	logic                   first_emit;
	logic                   slide;
	logic [WINDOW_BITS-1:0] seen_inc;
	logic [WINDOW_BITS-1:0] rep_base;
	logic [WINDOW_BITS-1:0] rep_in;

	assign filling    = seen_q < window_size_q;
	assign seen_inc   = seen_q + 1'b1;
	assign first_emit = usable && filling && (seen_inc == window_size_q);
	assign slide      = usable && !filling;
	assign rep_base   = first_emit ? (half_w + 1'b1) : {{(WINDOW_BITS-1){1'b0}}, 1'b1};
	// The final result also covers the trailing half-window.
	assign rep_in     = rep_base + (s_axis_tlast ? half_w : '0);

	// The sample leaving the window was written W beats ago, at ptr - W modulo
	// the ring depth. The sum below stays under twice the depth, so one
	// compare and subtract finishes the wrap.
	logic [IDX_W-1:0] old_raw;
	logic [IDX_W-1:0] old_wrap;
	logic [PTR_W-1:0] rd_addr;
	logic [PTR_W-1:0] ptr_next;

	assign old_raw  = IDX_W'(ptr_q) + IDX_W'(RING_DEPTH) - IDX_W'(window_size_q);
	assign old_wrap = (old_raw >= IDX_W'(RING_DEPTH)) ? (old_raw - IDX_W'(RING_DEPTH))
		: old_raw;
	assign rd_addr  = PTR_W'(old_wrap);
	assign ptr_next = (ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : (ptr_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_RESET;
			seen_q        <= '0;
			ptr_q         <= '0;
		end else if (cfg_wr_en) begin
			// A new width restarts the stream.
			window_size_q <= cfg_wr_data;
			seen_q        <= '0;
			ptr_q         <= '0;
		end else if (in_acc) begin
			if (s_axis_tlast) begin
				seen_q <= '0;
				ptr_q  <= '0;
			end else if (usable) begin
				if (filling) begin
					seen_q <= seen_inc;
				end
				ptr_q <= ptr_next;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sample ring. One read per accepted beat, plus a write while the window is
	// usable. The read returns the old contents, which is what a full-depth
	// window needs when both ports land on the same entry. A window of one reads
	// the entry written by the previous beat, which is already in the array by then.
	// ------------------------------------------------------------------
	logic [SB-1:0] ring_mem [RING_DEPTH];
	logic [SB-1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_s1 <= ring_mem[rd_addr];
			if (usable) begin
				ring_mem[ptr_q] <= in_sample;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: running-sum update.
	// ------------------------------------------------------------------
	logic                   vld_s1;
	logic                   emit_s1;
	logic                   slide_s1;
	logic                   last_s1;
	logic [SB-1:0]          smp_s1;
	logic [WINDOW_BITS-1:0] rep_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			emit_s1  <= first_emit || slide;
			slide_s1 <= slide;
			last_s1  <= s_axis_tlast;
			smp_s1   <= in_sample;
			rep_s1   <= rep_in;
		end
	end

	logic [SUM_W-1:0] smp_ext;
	logic [SUM_W-1:0] old_ext;
	logic [SUM_W-1:0] sum_new;

	assign smp_ext = {{WINDOW_BITS{smp_s1[SB-1]}}, smp_s1};
	assign old_ext = slide_s1 ? {{WINDOW_BITS{rd_s1[SB-1]}}, rd_s1} : '0;
	assign sum_new = sum_q + smp_ext - old_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cfg_wr_en) begin
			sum_q <= '0;
		end else if (advance && vld_s1) begin
			sum_q <= last_s1 ? '0 : sum_new;
		end
	end

	// ------------------------------------------------------------------
	// Division by the window width: sign and magnitude, then one quotient
	// bit per stage, most significant first. The magnitude of the sum is at
	// most W times 2^(SB-1), so SB quotient bits cover it.
	// ------------------------------------------------------------------
	logic [SUM_W-1:0]       div_rem_s  [SB+1];
	logic [SB-1:0]          div_q_s    [SB+1];
	logic [WINDOW_BITS-1:0] div_rep_s  [SB+1];
	logic [SB:0]            div_vld_s;
	logic [SB:0]            div_neg_s;
	logic [SB:0]            div_last_s;

	logic             sum_neg;
	logic [SUM_W-1:0] sum_mag;

	assign sum_neg = sum_new[SUM_W-1];
	assign sum_mag = sum_neg ? (~sum_new + 1'b1) : sum_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else if (advance) begin
			div_vld_s[0] <= vld_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			div_rem_s[0]  <= sum_mag;
			div_q_s[0]    <= '0;
			div_rep_s[0]  <= rep_s1;
			div_neg_s[0]  <= sum_neg;
			div_last_s[0] <= last_s1;
		end
	end

	for (genvar i = 0; i < SB; i++) begin : g_div
		localparam int BIT = SB - 1 - i;

		logic [SUM_W-1:0] dsr;
		logic             ge;

		assign dsr = SUM_W'(window_size_q) << BIT;
		assign ge  = div_rem_s[i] >= dsr;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[i+1] <= 1'b0;
			end else if (advance) begin
				div_vld_s[i+1] <= div_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				div_rem_s[i+1]  <= ge ? (div_rem_s[i] - dsr) : div_rem_s[i];
				div_q_s[i+1]    <= div_q_s[i] | (SB'(ge) << BIT);
				div_rep_s[i+1]  <= div_rep_s[i];
				div_neg_s[i+1]  <= div_neg_s[i];
				div_last_s[i+1] <= div_last_s[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register. Negating the magnitude quotient gives truncation
	// toward zero.
	// ------------------------------------------------------------------
	logic [SB-1:0]          out_avg_q;
	logic [WINDOW_BITS-1:0] out_rep_q;
	logic                   out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= div_vld_s[SB];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_avg_q  <= div_neg_s[SB] ? (~div_q_s[SB] + 1'b1) : div_q_s[SB];
			out_rep_q  <= div_rep_s[SB];
			out_last_q <= div_last_s[SB];
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_W'({out_rep_q, out_avg_q});
	assign m_axis_tlast  = out_last_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	// The fill count never runs past the window it is filling.
	`ASSERT_IMPL(a_seen_in_window, 1'b1, seen_q <= window_size_q)
	// Fill count and ring pointer start together after every stream end.
	`ASSERT_IMPL(a_ptr_with_seen, seen_q == '0, ptr_q == '0)
	// The pointer stays inside the ring.
	`ASSERT_IMPL(a_ptr_in_ring, 1'b1, 32'(ptr_q) < 32'(RING_DEPTH))
	// A closing result always carries the trailing half-window.
	`ASSERT_IMPL(a_last_covers_tail, out_vld_q && out_last_q, out_rep_q > half_w)
	// The running sum restarts after the stream's last beat leaves stage 1.
	`ASSERT_NEXT(a_sum_cleared, advance && vld_s1 && last_s1 && !cfg_wr_en, sum_q == '0)

endmodule

// ===== tb/tb_centered_moving_average_unit.sv =====
module tb_centered_moving_average_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import cma_pkg::*;

	localparam int RING         = RING_DEPTH_DEF;
	localparam int SMP_BITS     = SAMPLE_BITS_DEF;
	localparam int IN_BITS      = ((SMP_BITS + 7) / 8) * 8;
	localparam int OUT_BITS     = ((SMP_BITS + WINDOW_BITS + 7) / 8) * 8;
	// A beat that makes no result may still be in flight, so wait SETTLE_CYCLES
	// before touching the window register.
	localparam int SETTLE_CYCLES = 2 * (SMP_BITS + 3);
	localparam int RANDOM_ITEMS  = 1175;
	localparam int QUIET_AFTER   = 1100;

	// One result beat as the block presents it.
	typedef struct packed {
		logic signed [SMP_BITS-1:0]    average;
		logic        [WINDOW_BITS-1:0] repeat_count;
		logic                          stream_done;
	} avg_beat_t;

	// One row of the directed part: either a window write or a sample beat. Rows that
	// carry a spelled-out result use it in place of the one the window model gives.
	typedef struct packed {
		logic                          is_cfg;
		logic        [WINDOW_BITS-1:0] width;
		logic signed [SMP_BITS-1:0]    smp;
		logic                          lst;
		logic                          spelled;
		avg_beat_t                     res;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [WINDOW_BITS-1:0] cfg_wr_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_BITS-1:0]     s_axis_tdata;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_BITS-1:0]    m_axis_tdata;
	logic                   m_axis_tlast;

	centered_moving_average_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Window model state: the sample history, the exact window sum, how many samples
	// of the current stream are in, the next history slot and the window width.
	logic signed [SMP_BITS-1:0] history [0:RING-1];
	longint                     win_sum;
	int                         fill;
	int                         wr_ptr;
	int                         win;

	avg_beat_t pending_averages [$];
	int        fault_count;
	bit        idle_on;
	bit        quiet;
	int        hold_cycles;
	avg_beat_t seen_beat;
	avg_beat_t want_beat;

	function automatic void restart_stream();
		win_sum = 0;
		fill    = 0;
		wr_ptr  = 0;
	endfunction

	// Slides the window by one sample and returns 1 when an average comes out.
	function automatic bit slide_window(input logic signed [SMP_BITS-1:0] smp,
	                                    input logic lst, output avg_beat_t res);
		longint quotient;
		int     reps;
		int     oldest;
		bit     fired;
		fired = 1'b0;
		reps  = 0;
		res   = '0;
		if (win[0] && win <= RING) begin
			if (fill < win) begin
				win_sum += smp;
				fill++;
				// The first full window also stands in for the leading edge.
				if (fill == win) begin
					fired = 1'b1;
					reps  = win / 2 + 1;
				end
			end else begin
				oldest  = (wr_ptr + RING - win) % RING;
				win_sum = win_sum - history[oldest] + smp;
				fired   = 1'b1;
				reps    = 1;
			end
			history[wr_ptr] = smp;
			wr_ptr = (wr_ptr + 1) % RING;
		end else if (fill < 2047) begin
			// Even or zero widths only count samples.
			fill++;
		end
		if (fired) begin
			quotient = win_sum / win;
			// The closing sample also covers the trailing edge.
			if (lst)
				reps += win / 2;
			res.average      = quotient[SMP_BITS-1:0];
			res.repeat_count = reps[WINDOW_BITS-1:0];
			res.stream_done  = lst;
		end
		if (lst)
			restart_stream();
		return fired;
	endfunction

	function automatic stim_row_t cfg_row(input int w);
		stim_row_t r;
		r        = '0;
		r.is_cfg = 1'b1;
		r.width  = w[WINDOW_BITS-1:0];
		return r;
	endfunction

	function automatic stim_row_t smp_row(input int s, input bit lst);
		stim_row_t r;
		r     = '0;
		r.smp = s[SMP_BITS-1:0];
		r.lst = lst;
		return r;
	endfunction

	function automatic stim_row_t known_row(input int s, input bit lst,
	                                        input int a, input int reps, input bit done);
		stim_row_t r;
		r                  = smp_row(s, lst);
		r.spelled          = 1'b1;
		r.res.average      = a[SMP_BITS-1:0];
		r.res.repeat_count = reps[WINDOW_BITS-1:0];
		r.res.stream_done  = done;
		return r;
	endfunction

	task automatic report_fault(input string what, input avg_beat_t want, input avg_beat_t got);
		if (fault_count < 10)
			$display("%t %s: expected avg=%0d rep=%0d done=%0b, got avg=%0d rep=%0d done=%0b",
				$realtime, what, want.average, want.repeat_count, want.stream_done,
				got.average, got.repeat_count, got.stream_done);
		fault_count++;
	endtask

	// Stops sending and waits until every expected average has come back, then lets
	// enough cycles pass for a beat that makes no result to leave the pipeline.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input int w);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= w[WINDOW_BITS-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win = w;
		restart_stream();
	endtask

	// Offers one sample beat, holding it until accepted, and records what it should give.
	task automatic push_sample(input logic signed [SMP_BITS-1:0] smp, input logic lst,
	                           input bit spelled, input avg_beat_t spelled_res);
		avg_beat_t res;
		bit        fired;
		if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tlast  <= lst;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		fired = slide_window(smp, lst, res);
		if (spelled)
			pending_averages.push_back(spelled_res);
		else if (fired)
			pending_averages.push_back(res);
	endtask

	// Output back-pressure comes in bursts of random length.
	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles--;
		else if (idle_on && !quiet && $urandom_range(0, 7) == 0)
			hold_cycles = $urandom_range(1, 8);
		m_axis_tready <= (hold_cycles == 0);
	end

	// Every accepted result beat is matched against the oldest expected average.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_beat.average      = m_axis_tdata[SMP_BITS-1:0];
			seen_beat.repeat_count = m_axis_tdata[SMP_BITS +: WINDOW_BITS];
			seen_beat.stream_done  = m_axis_tlast;
			if (pending_averages.size() == 0) begin
				report_fault("unexpected result beat", '0, seen_beat);
			end else begin
				want_beat = pending_averages.pop_front();
				if (seen_beat !== want_beat)
					report_fault("result mismatch", want_beat, seen_beat);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb_centered_moving_average_unit: errors");
		$finish;
	end

	initial begin
		stim_row_t                  rows [$];
		stim_row_t                  row;
		logic signed [SMP_BITS-1:0] smp;
		logic [31:0]                rnd;
		int                         random_items;
		int                         phase_no;
		int                         w;
		int                         sel;
		int                         n_streams;
		int                         len;
		bit                         cut;

		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		hold_cycles   = 0;
		fault_count   = 0;
		idle_on       = 1'b1;
		quiet         = 1'b0;
		win           = int'(WINDOW_RESET);
		restart_stream();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A short stream under the reset width gives nothing.
		rows.push_back(smp_row(1, 0));
		rows.push_back(smp_row(-1, 1));
		// Width one: every sample is its own average, extremes pass through.
		rows.push_back(cfg_row(1));
		rows.push_back(known_row(32767, 0, 32767, 1, 0));
		rows.push_back(known_row(-32768, 0, -32768, 1, 0));
		rows.push_back(known_row(0, 1, 0, 1, 1));
		// Width three: leading edge, one slide, trailing edge.
		rows.push_back(cfg_row(3));
		rows.push_back(smp_row(5, 0));
		rows.push_back(smp_row(7, 0));
		rows.push_back(known_row(9, 0, 7, 2, 0));
		rows.push_back(known_row(-10, 1, 2, 2, 1));
		// Short stream, then a negative sum truncated toward zero on the closing sample.
		rows.push_back(smp_row(1, 0));
		rows.push_back(smp_row(2, 1));
		rows.push_back(smp_row(-1, 0));
		rows.push_back(smp_row(-1, 0));
		rows.push_back(known_row(0, 1, 0, 3, 1));
		// Even and zero widths never give a result.
		rows.push_back(cfg_row(2));
		rows.push_back(smp_row(100, 0));
		rows.push_back(smp_row(200, 1));
		rows.push_back(cfg_row(0));
		rows.push_back(smp_row(3, 1));
		// Largest width, stream far too short.
		rows.push_back(cfg_row(1023));
		rows.push_back(smp_row(32767, 1));
		// Width five full of the most negative sample.
		rows.push_back(cfg_row(5));
		repeat (4) rows.push_back(smp_row(-32768, 0));
		rows.push_back(known_row(-32768, 1, -32768, 5, 1));

		foreach (rows[i]) begin
			row = rows[i];
			if (row.is_cfg)
				write_window(int'(row.width));
			else
				push_sample(row.smp, row.lst, row.spelled, row.res);
		end

		// Random part. Each phase writes the window after the block has drained, then
		// sends a few streams, most of them long enough to fill the window. The first
		// phase runs the largest width once, long enough to wrap the ring.
		random_items = 0;
		phase_no     = 0;
		while (random_items < RANDOM_ITEMS) begin
			case (phase_no)
				0: w = 1023;
				default: begin
					sel = $urandom_range(0, 9);
					if (sel <= 5)
						w = 2 * $urandom_range(0, 7) + 1;
					else if (sel <= 7)
						w = 2 * $urandom_range(8, 64) + 1;
					else if (sel == 8)
						w = 2 * $urandom_range(0, 32);
					else
						w = 1;
				end
			endcase
			write_window(w);
			idle_on   = ($urandom_range(0, 3) != 0);
			quiet     = (random_items >= QUIET_AFTER);
			n_streams = (w == 1023) ? 1 : $urandom_range(1, 4);
			for (int s = 0; s < n_streams && random_items < RANDOM_ITEMS; s++) begin
				if (w % 2 == 0)
					len = $urandom_range(1, 20);
				else if (w == 1023)
					len = w + 2;
				else if ($urandom_range(0, 5) == 0)
					len = $urandom_range(1, (w > 1) ? w - 1 : 1);
				else
					len = w + $urandom_range(0, 30);
				// Now and then the stream is left open and the next width write cuts it.
				cut = (s == n_streams - 1) && ($urandom_range(0, 7) == 0);
				for (int k = 0; k < len && random_items < RANDOM_ITEMS; k++) begin
					rnd = $urandom;
					case ($urandom_range(0, 7))
						0: smp = 16'sh7fff;
						1: smp = 16'sh8000;
						default: smp = rnd[SMP_BITS-1:0];
					endcase
					push_sample(smp, (k == len - 1) && !cut, 1'b0, '0);
					random_items++;
				end
			end
			phase_no++;
		end

		s_axis_tvalid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_averages.size() != 0)
			report_fault("missing result beat", pending_averages[0], '0);

		if (fault_count == 0) begin
			$display("tb_centered_moving_average_unit: clean");
		end else begin
			$display("tb_centered_moving_average_unit: errors");
		end
		$finish;
	end

endmodule
